[src/fdm_pkg.sv]
// shared constants for the stereo flanger
package fdm_pkg;

	localparam int DEPTH_WORDS_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int SINE_ENTRIES_DEF = 1024;
	localparam int CHANNELS_DEF     = 2;

	localparam int SAMPLE_W = 16;
	localparam int SINE_W   = 16;

	localparam int MUL_BW     = 20;
	localparam int DIG_W      = 4;
	localparam int MUL_DIGITS = MUL_BW / DIG_W;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [2:0] REG_PHASE_STEP    = 3'd0;
	localparam logic [2:0] REG_CENTRE_DELAY  = 3'd1;
	localparam logic [2:0] REG_SWEEP_DEPTH   = 3'd2;
	localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd3;
	localparam logic [2:0] REG_WET_MIX       = 3'd4;

	localparam logic [21:0] PHASE_STEP_RST    = 22'd22370;
	localparam logic [17:0] CENTRE_DELAY_RST  = 18'd24576;
	localparam logic [17:0] SWEEP_DEPTH_RST   = 18'd17152;
	localparam logic [15:0] FEEDBACK_GAIN_RST = 16'd16384;
	localparam logic [15:0] WET_MIX_RST       = 16'd16384;

	localparam logic [16:0] WET_ONE = 17'd32768;

endpackage

[src/fdm_mul.sv]
// signed multiplier, one four-bit digit of the multiplier per cycle
module fdm_mul import fdm_pkg::*; #(
	parameter int AW = 17
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      accum,
	input  logic signed [AW-1:0]      a,
	input  logic signed [MUL_BW-1:0]  b,
	output logic                      done,
	output logic signed [AW+MUL_BW-1:0] p
);

	localparam int PW = AW + MUL_BW;
	localparam int CW = $clog2(MUL_DIGITS);

	logic signed [PW-1:0] mcand_q;
	logic [MUL_BW-1:0]    mplier_q;
	logic [CW-1:0]        cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic signed [PW-1:0] acc_q;
	logic                 last;
	logic signed [DIG_W:0] dig_s;
	logic signed [PW-1:0] pp;

	assign last  = (cnt_q == CW'(MUL_DIGITS - 1));
	assign dig_s = last ? $signed({mplier_q[DIG_W-1], mplier_q[DIG_W-1:0]})
	                    : $signed({1'b0, mplier_q[DIG_W-1:0]});
	assign pp    = mcand_q * dig_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= PW'(a);
			mplier_q <= b;
			if (!accum) acc_q <= '0;
		end else if (run_q) begin
			acc_q    <= acc_q + pp;
			mcand_q  <= mcand_q <<< DIG_W;
			mplier_q <= mplier_q >> DIG_W;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

[src/flanger_delay_modulator.sv]
// stereo flanger: sine lfo, interpolated delay read, feedback and dry/wet blend
//
//  channel  | signals                                   | flow
//  sample   | sample_valid sample_stall sample_left/right | frame in
//  result   | result_valid result_stall out_left/right    | blended frame out
//  config   | psel penable pwrite paddr pwdata prdata     | register access
//
// with two channels a frame runs from accept to the next possible accept through nine
// products in the digit-serial multiplier (five digits each) and the lookup, pointer,
// read, store and output steps.
// after reset the delay stores are cleared while sample_stall is high.
// a finished beat waits in the output register; the next frame is taken meanwhile.
module flanger_delay_modulator import fdm_pkg::*; #(
	parameter int DEPTH_WORDS  = DEPTH_WORDS_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
	parameter int CHANNELS     = CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic signed [SAMPLE_W-1:0] sample_left,
	input  logic signed [SAMPLE_W-1:0] sample_right,
	output logic                result_valid,
	input  logic                result_stall,
	output logic signed [SAMPLE_W-1:0] out_left,
	output logic signed [SAMPLE_W-1:0] out_right
);

	localparam int PTR_W = $clog2(DEPTH_WORDS);
	localparam int SIX_W = $clog2(SINE_ENTRIES);
	localparam int AW    = (SAMPLE_BITS + 1 > 16) ? SAMPLE_BITS + 1 : 16;
	localparam int PW    = AW + MUL_BW;
	localparam int DLY_W = (PTR_W + 10 > 22) ? PTR_W + 10 : 22;
	localparam int RP_W  = PTR_W + 8;
	localparam int ZW    = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic signed [DLY_W-1:0] DLY_LO = DLY_W'(256);
	localparam logic signed [DLY_W-1:0] DLY_HI = DLY_W'((DEPTH_WORDS - 2) * 256);
	localparam logic signed [DLY_W-1:0] TOTAL  = DLY_W'(DEPTH_WORDS * 256);
	localparam logic signed [PW-1:0] SAT_HI = PW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

	typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_ENTRIES];

	function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] r);
		logic [63:0] x, x2, pl, y;
		x  = (r << 30) / 64'(SINE_ENTRIES);
		x2 = (x * x) >> 30;
		pl = 64'd5026993 - ((x2 * 64'd172272) >> 30);
		pl = 64'd85569306 - ((x2 * pl) >> 30);
		pl = 64'd693598668 - ((x2 * pl) >> 30);
		pl = 64'd1686629713 - ((x2 * pl) >> 30);
		y  = (x * pl) >> 30;
		y  = (y * 64'd32767 + (64'd1 << 29)) >> 30;
		return (y > 64'd32767) ? SINE_W'(32767) : y[SINE_W-1:0];
	endfunction

	function automatic sine_rom_t build_sine();
		sine_rom_t rom;
		logic [63:0] u, q, r;
		logic [SINE_W-1:0] s;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			u = 64'(4 * i);
			q = u / 64'(SINE_ENTRIES);
			r = u % 64'(SINE_ENTRIES);
			s = q[0] ? quarter_sine(64'(SINE_ENTRIES) - r) : quarter_sine(r);
			rom[i] = q[1] ? -s : s;
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

	function automatic logic signed [PW-1:0] sat_f(input logic signed [PW-1:0] v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SINE, S_MSW, S_PTR, S_RDA, S_RDB, S_DIFF,
		S_MI, S_MF, S_MX, S_MD, S_WR, S_OUT
	} state_t;

	state_t state_q;

	logic [21:0] phase_step_q;
	logic [17:0] centre_q, sweep_q;
	logic signed [15:0] fb_q;
	logic [15:0] wet_q;

	logic [PTR_W-1:0] clr_q, wp_q;
	logic [31:0]      phase_q;
	logic             ch_q;
	logic             mul_wait_q;
	logic             out_valid_q;

	logic [SAMPLE_BITS-1:0] mem_l [DEPTH_WORDS];
	logic [SAMPLE_BITS-1:0] mem_r [DEPTH_WORDS];
	logic [SAMPLE_BITS-1:0] rd_l_q, rd_r_q;

	logic [SIX_W-1:0]            sidx_q;
	logic signed [SINE_W-1:0]    sine_q;
	logic signed [DLY_W-1:0]     delay_q;
	logic [PTR_W-1:0]            i0_q, i1_q;
	logic [7:0]                  frac_q;
	logic signed [SAMPLE_BITS-1:0] x_q [2];
	logic signed [SAMPLE_BITS-1:0] a_q [2];
	logic signed [SAMPLE_BITS:0]   dlt_q [2];
	logic signed [SAMPLE_BITS:0]   d_q [2];
	logic [SAMPLE_BITS-1:0]        w_q [2];
	logic signed [SAMPLE_W-1:0]    y_q [2];
	logic signed [SAMPLE_W-1:0]    out_l_q, out_r_q;

	logic cfg_wr, accept, can_out, clearing, mem_we, mem_re, is_mul, mul_start, mul_done;
	logic [PTR_W-1:0] mem_wa, mem_ra;
	logic signed [AW-1:0]     mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [PW-1:0]     mul_p, p_sh15, p_sh8;
	logic [SIX_W+31:0]        sidx_full;
	logic signed [DLY_W-1:0]  dly_raw, rp_diff;
	logic [RP_W-1:0]          rp;
	logic [16:0]              wetc;
	logic [ZW-1:0]            zx_l, zx_r;
	logic signed [PW-1:0]     w_sum;
	logic signed [PW-1:0]     w_sat, y_sat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[PADDR_W-1:2])
			REG_PHASE_STEP:    prdata = PDATA_W'(phase_step_q);
			REG_CENTRE_DELAY:  prdata = PDATA_W'(centre_q);
			REG_SWEEP_DEPTH:   prdata = PDATA_W'(sweep_q);
			REG_FEEDBACK_GAIN: prdata = PDATA_W'($unsigned(fb_q));
			REG_WET_MIX:       prdata = PDATA_W'(wet_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RST;
			centre_q     <= CENTRE_DELAY_RST;
			sweep_q      <= SWEEP_DEPTH_RST;
			fb_q         <= FEEDBACK_GAIN_RST;
			wet_q        <= WET_MIX_RST;
		end else if (cfg_wr) begin
			unique case (paddr[PADDR_W-1:2])
				REG_PHASE_STEP:    phase_step_q <= pwdata[21:0];
				REG_CENTRE_DELAY:  centre_q     <= pwdata[17:0];
				REG_SWEEP_DEPTH:   sweep_q      <= pwdata[17:0];
				REG_FEEDBACK_GAIN: fb_q         <= pwdata[15:0];
				REG_WET_MIX:       wet_q        <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign sample_stall = (state_q != S_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign can_out      = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign out_left     = out_l_q;
	assign out_right    = (CHANNELS == 1) ? '0 : out_r_q;

	assign is_mul    = (state_q == S_MSW) || (state_q == S_MI) || (state_q == S_MF) ||
	                   (state_q == S_MX) || (state_q == S_MD);
	assign mul_start = is_mul && !mul_wait_q;

	assign wetc = (wet_q > 16'd32768) ? WET_ONE : {1'b0, wet_q};

	always_comb begin
		unique case (state_q)
			S_MSW: begin
				mul_a = AW'(sine_q);
				mul_b = MUL_BW'(sweep_q);
			end
			S_MI: begin
				mul_a = AW'(dlt_q[ch_q]);
				mul_b = MUL_BW'(frac_q);
			end
			S_MF: begin
				mul_a = AW'(d_q[ch_q]);
				mul_b = MUL_BW'(fb_q);
			end
			S_MX: begin
				mul_a = AW'(x_q[ch_q]);
				mul_b = MUL_BW'(WET_ONE - wetc);
			end
			S_MD: begin
				mul_a = AW'(d_q[ch_q]);
				mul_b = MUL_BW'(wetc);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	fdm_mul #(.AW(AW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.accum  (state_q == S_MD),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign p_sh15 = mul_p >>> 15;
	assign p_sh8  = mul_p >>> 8;

	assign sidx_full = {{SIX_W{1'b0}}, phase_q} * (SIX_W + 32)'(SINE_ENTRIES);
	assign dly_raw   = $signed(DLY_W'(centre_q)) + p_sh15[DLY_W-1:0];
	assign rp_diff   = $signed({{(DLY_W-RP_W){1'b0}}, wp_q, 8'd0}) - delay_q;
	assign rp        = (rp_diff < 0) ? RP_W'(rp_diff + TOTAL) : RP_W'(rp_diff);

	assign zx_l = ZW'($unsigned(sample_left));
	assign zx_r = ZW'($unsigned(sample_right));

	assign w_sum = PW'(x_q[ch_q]) + p_sh15;
	assign w_sat = sat_f(w_sum);
	assign y_sat = sat_f(p_sh15);

	assign clearing = (state_q == S_CLEAR);
	assign mem_we   = clearing || (state_q == S_WR);
	assign mem_wa   = clearing ? clr_q : wp_q;
	assign mem_re   = (state_q == S_RDA) || (state_q == S_RDB);
	assign mem_ra   = (state_q == S_RDA) ? i0_q : i1_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_l[mem_wa] <= clearing ? '0 : w_q[0];
			mem_r[mem_wa] <= clearing ? '0 : w_q[1];
		end
		if (mem_re) begin
			rd_l_q <= mem_l[mem_ra];
			rd_r_q <= mem_r[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			wp_q        <= '0;
			phase_q     <= '0;
			ch_q        <= 1'b0;
			mul_wait_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (mul_start) mul_wait_q <= 1'b1;
			else if (mul_done) mul_wait_q <= 1'b0;
			if (state_q == S_OUT && can_out) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + PTR_W'(1);
					if (clr_q == PTR_W'(DEPTH_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (accept) state_q <= S_SINE;
				S_SINE: state_q <= S_MSW;
				S_MSW:  if (mul_done) state_q <= S_PTR;
				S_PTR:  state_q <= S_RDA;
				S_RDA:  state_q <= S_RDB;
				S_RDB:  state_q <= S_DIFF;
				S_DIFF: begin
					ch_q    <= 1'b0;
					state_q <= S_MI;
				end
				S_MI: if (mul_done) state_q <= S_MF;
				S_MF: if (mul_done) state_q <= S_MX;
				S_MX: if (mul_done) state_q <= S_MD;
				S_MD: begin
					if (mul_done) begin
						if (ch_q == 1'(CHANNELS - 1)) begin
							state_q <= S_WR;
						end else begin
							ch_q    <= 1'b1;
							state_q <= S_MI;
						end
					end
				end
				S_WR: begin
					wp_q    <= (wp_q == PTR_W'(DEPTH_WORDS - 1)) ? '0 : wp_q + PTR_W'(1);
					phase_q <= phase_q + 32'(phase_step_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (can_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q[0] <= $signed(zx_l[SAMPLE_BITS-1:0]);
			x_q[1] <= $signed(zx_r[SAMPLE_BITS-1:0]);
			sidx_q <= sidx_full[SIX_W+31:32];
		end
		if (state_q == S_SINE) sine_q <= SINE_ROM[sidx_q];
		if (state_q == S_MSW && mul_done) begin
			if (dly_raw < DLY_LO) delay_q <= DLY_LO;
			else if (dly_raw > DLY_HI) delay_q <= DLY_HI;
			else delay_q <= dly_raw;
		end
		if (state_q == S_PTR) begin
			i0_q   <= rp[RP_W-1:8];
			i1_q   <= (rp[RP_W-1:8] == PTR_W'(DEPTH_WORDS - 1)) ? '0
			        : rp[RP_W-1:8] + PTR_W'(1);
			frac_q <= rp[7:0];
		end
		if (state_q == S_RDB) begin
			a_q[0] <= rd_l_q;
			a_q[1] <= rd_r_q;
		end
		if (state_q == S_DIFF) begin
			dlt_q[0] <= $signed({rd_l_q[SAMPLE_BITS-1], rd_l_q}) -
			            $signed({a_q[0][SAMPLE_BITS-1], a_q[0]});
			dlt_q[1] <= $signed({rd_r_q[SAMPLE_BITS-1], rd_r_q}) -
			            $signed({a_q[1][SAMPLE_BITS-1], a_q[1]});
		end
		if (state_q == S_MI && mul_done)
			d_q[ch_q] <= (SAMPLE_BITS + 1)'(a_q[ch_q]) + p_sh8[SAMPLE_BITS:0];
		if (state_q == S_MF && mul_done) w_q[ch_q] <= w_sat[SAMPLE_BITS-1:0];
		if (state_q == S_MD && mul_done) y_q[ch_q] <= y_sat[SAMPLE_W-1:0];
		if (state_q == S_OUT && can_out) begin
			out_l_q <= y_q[0];
			out_r_q <= y_q[1];
		end
	end

endmodule

[src/fdm_check.sv]
// port checker for the flanger, bound to the top level
module fdm_check import fdm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_stall,
	input logic result_valid,
	input logic result_stall,
	input logic signed [SAMPLE_W-1:0] out_left,
	input logic signed [SAMPLE_W-1:0] out_right
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(out_left) && $stable(out_right))
		else $error("stalled result beat changed");

	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("second frame taken while one is in work");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> !$rose(result_valid))
		else $error("result beat right after frame accept");

endmodule

bind flanger_delay_modulator fdm_check u_fdm_check (.*);

[tb/tb_top.sv]
// stereo flanger bench: directed and random frames and register settings vs a built-in predictor
`timescale 1ns / 100ps

module tb_top;
	import fdm_pkg::*;

	localparam int DEPTH = 1024;
	localparam int SINES = 1024;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [15:0] sample_left = '0, sample_right = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [15:0] out_left, out_right;

	flanger_delay_modulator i_dut (.*);

	int sine_lut [SINES];
	int echo_mem [2][DEPTH];
	int head_ptr;
	longint unsigned lfo_acc;
	int unsigned rate_reg, centre_reg, sweep_reg, mix_reg;
	int gain_reg;

	frame_t pending_frames[$];
	frame_t blended_frames[$];
	int mismatches = 0;
	int send_idle_pct = 0, stall_pct = 0;
	longint cycles = 0;
	bit in_taken = 1'b0;

	initial forever #6 clk = ~clk;

	function automatic longint floor_div(longint v, int sh);
		return v >>> sh;
	endfunction

	function automatic longint clip16(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function automatic int quarter_wave(longint unsigned r, longint unsigned n);
		longint unsigned x, x2, p, y;
		x = (r << 30) / n;
		x2 = (x * x) >> 30;
		p = 64'd5026993 - ((x2 * 64'd172272) >> 30);
		p = 64'd85569306 - ((x2 * p) >> 30);
		p = 64'd693598668 - ((x2 * p) >> 30);
		p = 64'd1686629713 - ((x2 * p) >> 30);
		y = (x * p) >> 30;
		y = (y * 32767 + (64'd1 << 29)) >> 30;
		return y > 32767 ? 32767 : int'(y);
	endfunction

	task automatic init_flanger_model();
		int q, r, s;
		for (int i = 0; i < SINES; i++) begin
			q = (4 * i) / SINES;
			r = (4 * i) % SINES;
			s = (q & 1) ? quarter_wave(SINES - r, SINES) : quarter_wave(r, SINES);
			sine_lut[i] = (q & 2) ? -s : s;
		end
		foreach (echo_mem[c, k]) echo_mem[c][k] = 0;
		head_ptr = 0;
		lfo_acc = 0;
		rate_reg = 22370;
		centre_reg = 24576;
		sweep_reg = 17152;
		gain_reg = 16384;
		mix_reg = 16384;
	endtask

	function automatic frame_t flanger_predict(frame_t f);
		frame_t o;
		longint dly, rp, frac, wet, x, a, b, d, w, y;
		int i0, i1;
		dly = longint'(centre_reg) +
			floor_div(longint'(sweep_reg) * sine_lut[(lfo_acc * SINES) >> 32], 15);
		if (dly < 256) dly = 256;
		if (dly > (DEPTH - 2) * 256) dly = (DEPTH - 2) * 256;
		wet = mix_reg > 32768 ? 32768 : mix_reg;
		rp = (longint'(head_ptr) * 256 + DEPTH * 256 - dly) % (DEPTH * 256);
		i0 = int'(rp >> 8) % DEPTH;
		i1 = (i0 + 1) % DEPTH;
		frac = rp & 255;
		for (int c = 0; c < 2; c++) begin
			x = c ? f.right : f.left;
			a = echo_mem[c][i0];
			b = echo_mem[c][i1];
			d = a + floor_div((b - a) * frac, 8);
			w = clip16(x + floor_div(longint'(gain_reg) * d, 15));
			y = clip16(floor_div(x * (32768 - wet) + d * wet, 15));
			echo_mem[c][head_ptr] = int'(w);
			if (c) o.right = y[15:0]; else o.left = y[15:0];
		end
		head_ptr = (head_ptr + 1) % DEPTH;
		lfo_acc = (lfo_acc + rate_reg) & 64'hFFFF_FFFF;
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		mismatches++;
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= PADDR_W'(idx) << 2; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_PHASE_STEP: rate_reg = val & 32'h3FFFFF;
			REG_CENTRE_DELAY: centre_reg = val & 32'h3FFFF;
			REG_SWEEP_DEPTH: sweep_reg = val & 32'h3FFFF;
			REG_FEEDBACK_GAIN: gain_reg = int'(signed'(val[15:0]));
			default: mix_reg = val & 32'hFFFF;
		endcase
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!sample_valid || in_taken) begin
				in_taken = 1'b0;
				if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					sample_valid <= 1'b1;
					sample_left <= pending_frames[0].left;
					sample_right <= pending_frames[0].right;
				end else begin
					sample_valid <= 1'b0;
				end
			end
			result_stall <= $urandom_range(99) < stall_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		frame_t want;
		cycles++;
		if (arst_n && sample_valid && !sample_stall) begin
			void'(pending_frames.pop_front());
			blended_frames.push_back(flanger_predict('{sample_left, sample_right}));
			in_taken = 1'b1;
		end
		if (arst_n && result_valid && !result_stall) begin
			if (blended_frames.size() == 0) begin
				report_mismatch("unexpected beat", out_left, 0);
			end else begin
				want = blended_frames.pop_front();
				if (out_left !== want.left) report_mismatch("out_left", out_left, want.left);
				if (out_right !== want.right)
					report_mismatch("out_right", out_right, want.right);
			end
		end
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic queue_frame(int l, int r);
		pending_frames.push_back('{16'(l), 16'(r)});
	endtask

	task automatic drain();
		while (pending_frames.size() > 0 || sample_valid || blended_frames.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_settings(bit extreme);
		write_reg(REG_PHASE_STEP, extreme ? ($urandom_range(1) ? 4194303 : 0)
			: $urandom_range(200000));
		write_reg(REG_CENTRE_DELAY, extreme ? ($urandom_range(1) ? 261632 : 0)
			: $urandom_range(261632));
		write_reg(REG_SWEEP_DEPTH, extreme ? ($urandom_range(1) ? 261632 : 0)
			: $urandom_range(261632));
		write_reg(REG_FEEDBACK_GAIN, extreme ? ($urandom_range(1) ? 29491 : -29491)
			: $urandom_range(65535));
		write_reg(REG_WET_MIX, extreme ? ($urandom_range(1) ? 65535 : 32768)
			: $urandom_range(32768));
	endtask

	initial begin
		int idle_set [4][2] = '{'{0, 0}, '{66, 0}, '{0, 66}, '{32, 32}};
		init_flanger_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// directed: extremes at reset settings, then max feedback and full wet, then dry
		queue_frame(32767, -32768);
		queue_frame(-32768, 32767);
		queue_frame(0, 0);
		queue_frame(-1, 1);
		repeat (6) queue_frame(32767, 32767);
		drain();
		write_reg(REG_FEEDBACK_GAIN, 29491);
		write_reg(REG_WET_MIX, 65535);
		write_reg(REG_CENTRE_DELAY, 0);
		repeat (6) queue_frame(-32768, -32768);
		drain();
		write_reg(REG_CENTRE_DELAY, 261632);
		write_reg(REG_SWEEP_DEPTH, 261632);
		write_reg(REG_FEEDBACK_GAIN, -29491);
		write_reg(REG_WET_MIX, 0);
		write_reg(REG_PHASE_STEP, 4194303);
		repeat (6) queue_frame($urandom_range(65535), $urandom_range(65535));
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct = idle_set[ph % 4][0];
			stall_pct = idle_set[ph % 4][1];
			random_settings(ph == 3 || ph == 6);
			for (int n = 0; n < 110; n++) begin
				case ($urandom_range(3))
					0: queue_frame($urandom_range(1) ? 32767 : -32768,
						$urandom_range(1) ? 32767 : -32768);
					default: queue_frame($urandom_range(65535), $urandom_range(65535));
				endcase
			end
			drain();
		end
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
src/fdm_pkg.sv
src/fdm_mul.sv
src/flanger_delay_modulator.sv
src/fdm_check.sv
tb/tb_top.sv
